// ===== hdl/ncc_pkg.sv =====
package ncc_pkg;

  localparam int VERTICES = 1024;
  localparam int EDGES    = 4096;
  localparam int VW       = $clog2(VERTICES);
  localparam int EW       = $clog2(EDGES);
  localparam int VCW      = VW + 1;
  localparam int ECW      = EW + 1;
  localparam int DW       = 25;
  localparam int LPW      = 13;
  localparam int CFG_DW   = 13;
  localparam int CFG_IW   = 1;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_RUN   = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [CFG_IW-1:0] CFG_VERTEX_COUNT = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_EDGE_COUNT   = 1'b1;

  localparam logic [VCW-1:0] VCOUNT_RESET = VCW'(VERTICES);
  localparam logic [LPW-1:0] TALLY_MAX    = {LPW{1'b1}};

  typedef struct packed {
    logic [VW-1:0] src;
    logic [VW-1:0] dst;
    logic          pos;
  } edge_t;

  typedef struct packed {
    logic [DW-1:0] dval;
    logic          pv;
    logic [EW-1:0] pred;
  } dent_t;

  typedef struct packed {
    logic [1:0]    kind;
    logic [EW-1:0] edge_index;
    logic [VW-1:0] edge_source;
    logic [VW-1:0] edge_target;
    logic          edge_positive;
  } item_t;

  typedef struct packed {
    logic [LPW-1:0] lp_value;
    logic [LPW-1:0] cycles_cancelled;
    logic [VW-1:0]  read_source;
    logic [VW-1:0]  read_target;
    logic           read_positive;
  } res_t;

endpackage

// ===== hdl/ncc_if.sv =====
interface ncc_in_if import ncc_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [1:0]    kind;
  logic [EW-1:0] edge_index;
  logic [VW-1:0] edge_source;
  logic [VW-1:0] edge_target;
  logic          edge_positive;

  modport source (output valid, kind, edge_index, edge_source, edge_target, edge_positive,
                  input ready);
  modport sink   (input valid, kind, edge_index, edge_source, edge_target, edge_positive,
                  output ready);
endinterface

interface ncc_out_if import ncc_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [LPW-1:0] lp_value;
  logic [LPW-1:0] cycles_cancelled;
  logic [VW-1:0]  read_source;
  logic [VW-1:0]  read_target;
  logic           read_positive;

  modport source (output valid, lp_value, cycles_cancelled, read_source, read_target,
                  read_positive, input ready);
  modport sink   (input valid, lp_value, cycles_cancelled, read_source, read_target,
                  read_positive, output ready);
endinterface

// ===== hdl/ncc_ram.sv =====
module ncc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/ncc_engine.sv =====
module ncc_engine import ncc_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  item_t          item,
  input  logic [VCW-1:0] nv,
  input  logic [ECW-1:0] ne,
  output logic           idle,
  output logic           res_valid,
  input  logic           res_take,
  output res_t           res
);

  typedef enum logic [22:0] {
    S_IDLE    = 23'h000001,
    S_RD_WAIT = 23'h000002,
    S_INIT    = 23'h000004,
    S_R_EDGE  = 23'h000008,
    S_R_DU    = 23'h000010,
    S_R_DV    = 23'h000020,
    S_R_CMP   = 23'h000040,
    S_L_EDGE  = 23'h000080,
    S_L_DU    = 23'h000100,
    S_L_DV    = 23'h000200,
    S_L_CMP   = 23'h000400,
    S_CLR     = 23'h000800,
    S_W_MARK  = 23'h001000,
    S_W_EDGE  = 23'h002000,
    S_W_T     = 23'h004000,
    S_W_CHK   = 23'h008000,
    S_V_EDGE  = 23'h010000,
    S_V_T     = 23'h020000,
    S_V_CHK   = 23'h040000,
    S_F_LIST  = 23'h080000,
    S_F_EDGE  = 23'h100000,
    S_F_WR    = 23'h200000,
    S_DONE    = 23'h400000
  } state_t;

  state_t         state_r, state_nxt;
  logic [ECW-1:0] j_r, j_nxt;
  logic [VCW-1:0] pass_r, pass_nxt;
  logic [VCW-1:0] cnt_r, cnt_nxt;
  logic [VCW-1:0] n_r, n_nxt;
  logic           changed_r, changed_nxt;
  logic           neg0_r, neg0_nxt;
  logic           mode2_r, mode2_nxt;
  edge_t          e_r, e_nxt;
  dent_t          du_r, du_nxt;
  logic [EW-1:0]  p_r, p_nxt;
  logic [VW-1:0]  t_r, t_nxt;
  logic [LPW-1:0] lp_r, lp_nxt;
  logic [LPW-1:0] tally_r, tally_nxt;
  res_t           res_r, res_nxt;

  logic           e_we;
  logic [EW-1:0]  e_waddr, e_raddr;
  edge_t          e_wdata, e_rd;
  logic           d_we;
  logic [VW-1:0]  d_waddr, d_raddr;
  dent_t          d_wdata, d_rd;
  logic           v_we;
  logic [VW-1:0]  v_waddr, v_raddr;
  logic           v_wdata, v_rd;
  logic           l_we;
  logic [VW-1:0]  l_waddr, l_raddr;
  logic [EW-1:0]  l_wdata, l_rd;

  logic [DW-1:0]  cand;
  logic           usable;
  logic [VCW-1:0] pass_inc;

  ncc_ram #(.WIDTH($bits(edge_t)), .DEPTH(EDGES)) u_edges (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata), .raddr(e_raddr), .rdata(e_rd)
  );
  ncc_ram #(.WIDTH($bits(dent_t)), .DEPTH(VERTICES)) u_dist (
    .clk, .we(d_we), .waddr(d_waddr), .wdata(d_wdata), .raddr(d_raddr), .rdata(d_rd)
  );
  ncc_ram #(.WIDTH(1), .DEPTH(VERTICES)) u_mark (
    .clk, .we(v_we), .waddr(v_waddr), .wdata(v_wdata), .raddr(v_raddr), .rdata(v_rd)
  );
  ncc_ram #(.WIDTH(EW), .DEPTH(VERTICES)) u_cycle (
    .clk, .we(l_we), .waddr(l_waddr), .wdata(l_wdata), .raddr(l_raddr), .rdata(l_rd)
  );

  assign cand     = e_r.pos ? du_r.dval + DW'(1) : du_r.dval - DW'(1);
  assign usable   = ({1'b0, e_rd.src} < nv) && ({1'b0, e_rd.dst} < nv);
  assign pass_inc = pass_r + VCW'(1);

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  always_comb begin
    state_nxt   = state_r;
    j_nxt       = j_r;
    pass_nxt    = pass_r;
    cnt_nxt     = cnt_r;
    n_nxt       = n_r;
    changed_nxt = changed_r;
    neg0_nxt    = neg0_r;
    mode2_nxt   = mode2_r;
    e_nxt       = e_r;
    du_nxt      = du_r;
    p_nxt       = p_r;
    t_nxt       = t_r;
    lp_nxt      = lp_r;
    tally_nxt   = tally_r;
    res_nxt     = res_r;
    e_we        = 1'b0;
    e_waddr     = item.edge_index;
    e_wdata     = '{src: item.edge_source, dst: item.edge_target, pos: item.edge_positive};
    e_raddr     = item.edge_index;
    d_we        = 1'b0;
    d_waddr     = cnt_r[VW-1:0];
    d_wdata     = '{dval: (cnt_r == '0) ? '0 : {{(DW-VCW){1'b0}}, nv}, pv: 1'b0, pred: '0};
    d_raddr     = e_rd.src;
    v_we        = 1'b0;
    v_waddr     = cnt_r[VW-1:0];
    v_wdata     = 1'b0;
    v_raddr     = e_rd.src;
    l_we        = 1'b0;
    l_waddr     = n_r[VW-1:0];
    l_wdata     = p_r;
    l_raddr     = cnt_r[VW-1:0];
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (item.kind)
            KIND_WRITE: e_we = 1'b1;
            KIND_RUN: begin
              tally_nxt = '0;
              cnt_nxt   = '0;
              state_nxt = S_INIT;
            end
            KIND_READ: state_nxt = S_RD_WAIT;
            default: ;
          endcase
        end
      end
      S_RD_WAIT: begin
        res_nxt   = '{lp_value: '0, cycles_cancelled: '0, read_source: e_rd.src,
                      read_target: e_rd.dst, read_positive: e_rd.pos};
        state_nxt = S_DONE;
      end
      S_INIT: begin
        d_we    = 1'b1;
        cnt_nxt = cnt_r + VCW'(1);
        if (cnt_r + VCW'(1) == nv) begin
          j_nxt       = '0;
          pass_nxt    = '0;
          changed_nxt = 1'b0;
          neg0_nxt    = 1'b0;
          state_nxt   = S_R_EDGE;
        end
      end
      S_R_EDGE: begin
        e_raddr = j_r[EW-1:0];
        if (j_r == ne) begin
          j_nxt = '0;
          if (neg0_r || !changed_r || pass_inc >= nv) begin
            state_nxt = S_L_EDGE;
          end else begin
            pass_nxt    = pass_inc;
            changed_nxt = 1'b0;
          end
        end else begin
          state_nxt = S_R_DU;
        end
      end
      S_R_DU: begin
        e_nxt = e_rd;
        if (usable) begin
          state_nxt = S_R_DV;
        end else begin
          j_nxt     = j_r + ECW'(1);
          state_nxt = S_R_EDGE;
        end
      end
      S_R_DV: begin
        du_nxt    = d_rd;
        d_raddr   = e_r.dst;
        state_nxt = S_R_CMP;
      end
      S_R_CMP: begin
        d_waddr = e_r.dst;
        d_wdata = '{dval: cand, pv: 1'b1, pred: j_r[EW-1:0]};
        if ($signed(d_rd.dval) > $signed(cand)) begin
          d_we        = 1'b1;
          changed_nxt = 1'b1;
          if (e_r.dst == '0) begin
            neg0_nxt = cand[DW-1];
          end
        end
        j_nxt     = j_r + ECW'(1);
        state_nxt = S_R_EDGE;
      end
      S_L_EDGE: begin
        e_raddr = j_r[EW-1:0];
        if (j_r == ne) begin
          res_nxt   = '{lp_value: lp_r, cycles_cancelled: tally_r, read_source: '0,
                        read_target: '0, read_positive: 1'b0};
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_L_DU;
        end
      end
      S_L_DU: begin
        e_nxt = e_rd;
        if (usable) begin
          state_nxt = S_L_DV;
        end else begin
          j_nxt     = j_r + ECW'(1);
          state_nxt = S_L_EDGE;
        end
      end
      S_L_DV: begin
        du_nxt    = d_rd;
        d_raddr   = e_r.dst;
        state_nxt = S_L_CMP;
      end
      S_L_CMP: begin
        if (($signed(cand) < $signed(d_rd.dval)) && du_r.pv) begin
          cnt_nxt   = '0;
          mode2_nxt = 1'b0;
          state_nxt = S_CLR;
        end else begin
          j_nxt     = j_r + ECW'(1);
          state_nxt = S_L_EDGE;
        end
      end
      S_CLR: begin
        v_we    = 1'b1;
        cnt_nxt = cnt_r + VCW'(1);
        if (cnt_r + VCW'(1) == nv) begin
          if (mode2_r) begin
            n_nxt     = '0;
            state_nxt = S_V_EDGE;
          end else begin
            state_nxt = S_W_MARK;
          end
        end
      end
      S_W_MARK: begin
        v_we      = 1'b1;
        v_waddr   = e_r.src;
        v_wdata   = 1'b1;
        p_nxt     = du_r.pred;
        state_nxt = S_W_EDGE;
      end
      S_W_EDGE: begin
        e_raddr   = p_r;
        state_nxt = S_W_T;
      end
      S_W_T: begin
        t_nxt     = e_rd.src;
        state_nxt = S_W_CHK;
      end
      S_W_CHK: begin
        if (v_rd) begin
          mode2_nxt = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_CLR;
        end else begin
          v_we    = 1'b1;
          v_waddr = t_r;
          v_wdata = 1'b1;
          if (d_rd.pv) begin
            p_nxt     = d_rd.pred;
            state_nxt = S_W_EDGE;
          end else begin
            j_nxt     = j_r + ECW'(1);
            state_nxt = S_L_EDGE;
          end
        end
      end
      S_V_EDGE: begin
        e_raddr = p_r;
        if (n_r == nv) begin
          cnt_nxt   = '0;
          state_nxt = S_F_LIST;
        end else begin
          state_nxt = S_V_T;
        end
      end
      S_V_T: begin
        t_nxt     = e_rd.src;
        state_nxt = S_V_CHK;
      end
      S_V_CHK: begin
        if (v_rd) begin
          cnt_nxt   = '0;
          state_nxt = S_F_LIST;
        end else begin
          l_we    = 1'b1;
          n_nxt   = n_r + VCW'(1);
          v_we    = 1'b1;
          v_waddr = t_r;
          v_wdata = 1'b1;
          if (d_rd.pv) begin
            p_nxt     = d_rd.pred;
            state_nxt = S_V_EDGE;
          end else begin
            cnt_nxt   = '0;
            state_nxt = S_F_LIST;
          end
        end
      end
      S_F_LIST: begin
        if (cnt_r == n_r) begin
          tally_nxt = tally_r + LPW'(1);
          if (tally_r + LPW'(1) == TALLY_MAX) begin
            res_nxt   = '{lp_value: lp_r, cycles_cancelled: TALLY_MAX, read_source: '0,
                          read_target: '0, read_positive: 1'b0};
            state_nxt = S_DONE;
          end else begin
            cnt_nxt   = '0;
            state_nxt = S_INIT;
          end
        end else begin
          state_nxt = S_F_EDGE;
        end
      end
      S_F_EDGE: begin
        p_nxt     = l_rd;
        e_raddr   = l_rd;
        state_nxt = S_F_WR;
      end
      S_F_WR: begin
        e_we      = 1'b1;
        e_waddr   = p_r;
        e_wdata   = '{src: e_rd.dst, dst: e_rd.src, pos: ~e_rd.pos};
        lp_nxt    = e_rd.pos ? lp_r - LPW'(1) : lp_r + LPW'(1);
        cnt_nxt   = cnt_r + VCW'(1);
        state_nxt = S_F_LIST;
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lp_r    <= '0;
      tally_r <= '0;
    end else begin
      state_r <= state_nxt;
      lp_r    <= lp_nxt;
      tally_r <= tally_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r       <= j_nxt;
    pass_r    <= pass_nxt;
    cnt_r     <= cnt_nxt;
    n_r       <= n_nxt;
    changed_r <= changed_nxt;
    neg0_r    <= neg0_nxt;
    mode2_r   <= mode2_nxt;
    e_r       <= e_nxt;
    du_r      <= du_nxt;
    p_r       <= p_nxt;
    t_r       <= t_nxt;
    res_r     <= res_nxt;
  end

endmodule

// ===== hdl/negative_cycle_cancelling.sv =====
// Negative cycle cancelling over a table of +1/-1 edges.
// in_ch carries requests: write edge, run, read edge. out_ch returns one
// result for run and read requests, none for writes (unknown kinds are dropped).
// cfg_we/cfg_index/cfg_data set vertex_count (0) and edge_count (1); the user
// must write them only while idle, the block itself does not enforce it.
// Edge writes are taken one per cycle while the engine is idle. A read request
// passes the edge table read, the S_RD_WAIT and S_DONE states and the output
// register before out_ch.valid rises; the next request is taken once idle.
// A run iterates until no cycle is left or the tally reaches TALLY_MAX; per round:
// vertex table init, relaxation passes, a search for a cycle, a mark clear before
// each walk, walk steps, cycle edge flips. All steps share the edge table read port.
// Reset clears control state, the LP total and config registers
// (vertex_count 1024, edge_count 0); the edge table holds garbage until written.
// The output register frees the engine as soon as it takes the result. While
// the receiver stalls one result waits there and the engine may take writes and one
// more run or read; once that result is ready it holds and no further request is taken.
module negative_cycle_cancelling import ncc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  ncc_in_if.sink            in_ch,
  ncc_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  logic [VCW-1:0] vcount_r;
  logic [ECW-1:0] ecount_r;
  logic [VCW-1:0] nv;
  logic [ECW-1:0] ne;
  logic           idle, accept, res_valid, res_take;
  item_t          item;
  res_t           res, out_r;
  logic           out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= VCOUNT_RESET;
      ecount_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VERTEX_COUNT: vcount_r <= cfg_data[VCW-1:0];
        CFG_EDGE_COUNT:   ecount_r <= cfg_data[ECW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    nv = vcount_r;
    if (vcount_r == '0) begin
      nv = VCW'(1);
    end else if (vcount_r > VCW'(VERTICES)) begin
      nv = VCW'(VERTICES);
    end
    ne = (ecount_r > ECW'(EDGES)) ? ECW'(EDGES) : ecount_r;
  end

  assign item = '{kind: in_ch.kind, edge_index: in_ch.edge_index,
                  edge_source: in_ch.edge_source, edge_target: in_ch.edge_target,
                  edge_positive: in_ch.edge_positive};
  assign in_ch.ready = idle;
  assign accept      = in_ch.valid && idle;
  assign res_take    = !out_valid_r || out_ch.ready;

  ncc_engine u_engine (
    .clk, .rst_n, .accept, .item, .nv, .ne, .idle, .res_valid, .res_take, .res
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_r <= res;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.lp_value         = out_r.lp_value;
  assign out_ch.cycles_cancelled = out_r.cycles_cancelled;
  assign out_ch.read_source      = out_r.read_source;
  assign out_ch.read_target      = out_r.read_target;
  assign out_ch.read_positive    = out_r.read_positive;

endmodule

// ===== tb/tb_negative_cycle_cancelling.sv =====
module tb_negative_cycle_cancelling;
  import ncc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  ncc_in_if in_ch ();
  ncc_out_if out_ch ();

  negative_cycle_cancelling dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // graph mirror
  logic [VW-1:0] g_src [EDGES];
  logic [VW-1:0] g_dst [EDGES];
  bit g_pos [EDGES];
  bit g_written [EDGES];
  int dist_v [VERTICES];
  int pred_v [VERTICES];
  bit has_pred [VERTICES];
  bit marked [VERTICES];
  int cycle_edges [VERTICES];
  int vcount_reg = 1024;
  int ecount_reg = 0;
  logic [LPW-1:0] lp_acc = '0;

  item_t request_q[$];
  res_t result_q[$];
  int written_idx[$];
  int errors = 0;
  int n_runs = 0, n_reads = 0, n_writes = 0, n_cancels = 0, n_results = 0;
  bit in_taken = 1'b0;

  function automatic bit usable(int j, int nv);
    return g_src[j] < nv && g_dst[j] < nv;
  endfunction

  function automatic int wt(int j);
    return g_pos[j] ? 1 : -1;
  endfunction

  task automatic relax_edges(input int nv, input int ne);
    int cand;
    bit changed;
    for (int i = 0; i < nv; i++) begin
      dist_v[i] = nv;
      has_pred[i] = 0;
      pred_v[i] = 0;
    end
    dist_v[0] = 0;
    for (int pass = 0; pass < nv; pass++) begin
      changed = 0;
      for (int j = 0; j < ne; j++) begin
        if (usable(j, nv)) begin
          cand = dist_v[g_src[j]] + wt(j);
          if (dist_v[g_dst[j]] > cand) begin
            dist_v[g_dst[j]] = cand;
            pred_v[g_dst[j]] = j;
            has_pred[g_dst[j]] = 1;
            changed = 1;
          end
        end
      end
      if (dist_v[0] < 0 || !changed) break;
    end
  endtask

  task automatic find_cycle(input int nv, input int ne, output int n);
    int u, v, p, t;
    bit found;
    n = 0;
    for (int j = 0; j < ne; j++) begin
      if (!usable(j, nv)) continue;
      u = g_src[j];
      v = g_dst[j];
      if (!(dist_v[u] + wt(j) < dist_v[v]) || !has_pred[u]) continue;
      for (int i = 0; i < VERTICES; i++) marked[i] = 0;
      marked[u] = 1;
      p = pred_v[u];
      found = 0;
      while (1) begin
        t = g_src[p];
        if (marked[t]) begin
          found = 1;
          break;
        end
        marked[t] = 1;
        if (!has_pred[t]) break;
        p = pred_v[t];
      end
      if (!found) continue;
      for (int i = 0; i < VERTICES; i++) marked[i] = 0;
      while (n < nv && !marked[g_src[p]]) begin
        cycle_edges[n] = p;
        n++;
        t = g_src[p];
        marked[t] = 1;
        if (!has_pred[t]) break;
        p = pred_v[t];
      end
      return;
    end
  endtask

  task automatic predict_cancel(output res_t r);
    int nv, ne, n, j;
    logic [LPW-1:0] tally;
    logic [VW-1:0] s;
    nv = vcount_reg < 1 ? 1 : (vcount_reg > VERTICES ? VERTICES : vcount_reg);
    ne = ecount_reg > EDGES ? EDGES : ecount_reg;
    tally = '0;
    while (tally < TALLY_MAX) begin
      relax_edges(nv, ne);
      find_cycle(nv, ne, n);
      if (n == 0) break;
      for (int i = 0; i < n; i++) begin
        j = cycle_edges[i];
        s = g_src[j];
        g_src[j] = g_dst[j];
        g_dst[j] = s;
        g_pos[j] = !g_pos[j];
        lp_acc = lp_acc + (g_pos[j] ? LPW'(1) : TALLY_MAX);
      end
      tally++;
    end
    n_cancels += tally;
    r = '0;
    r.lp_value = lp_acc;
    r.cycles_cancelled = tally;
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  always @(posedge clk) begin
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
  end

  // driver: bursts with gaps
  int burst_left = 0, gap_left = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (request_q.size() > 0) begin
        item_t it;
        it = request_q.pop_front();
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.kind <= it.kind;
        in_ch.edge_index <= it.edge_index;
        in_ch.edge_source <= it.edge_source;
        in_ch.edge_target <= it.edge_target;
        in_ch.edge_positive <= it.edge_positive;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern
  int stall_mode = 0, stall_cnt = 0;
  always @(negedge clk) begin
    stall_cnt++;
    if (stall_cnt % 64 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= 1'($urandom_range(0, 1));
      2: out_ch.ready <= (stall_cnt % 4 == 0);
      default: out_ch.ready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // prediction on accept, checking on result
  always @(posedge clk) begin
    res_t r, e;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      case (in_ch.kind)
        KIND_WRITE: begin
          g_src[in_ch.edge_index] = in_ch.edge_source;
          g_dst[in_ch.edge_index] = in_ch.edge_target;
          g_pos[in_ch.edge_index] = in_ch.edge_positive;
          n_writes++;
        end
        KIND_RUN: begin
          predict_cancel(r);
          result_q = {result_q, r};
          n_runs++;
        end
        KIND_READ: begin
          r = '0;
          r.read_source = g_src[in_ch.edge_index];
          r.read_target = g_dst[in_ch.edge_index];
          r.read_positive = g_pos[in_ch.edge_index];
          result_q = {result_q, r};
          n_reads++;
        end
        default: ;
      endcase
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (result_q.size() == 0) begin
        report("unexpected result", 0, 0);
      end else begin
        e = result_q.pop_front();
        if (out_ch.lp_value !== e.lp_value) report("lp_value", out_ch.lp_value, e.lp_value);
        if (out_ch.cycles_cancelled !== e.cycles_cancelled)
          report("cycles_cancelled", out_ch.cycles_cancelled, e.cycles_cancelled);
        if (out_ch.read_source !== e.read_source)
          report("read_source", out_ch.read_source, e.read_source);
        if (out_ch.read_target !== e.read_target)
          report("read_target", out_ch.read_target, e.read_target);
        if (out_ch.read_positive !== e.read_positive)
          report("read_positive", out_ch.read_positive, e.read_positive);
      end
    end
  end

  function automatic item_t mk(input logic [1:0] k, input int idx, input int s, input int d,
                               input bit p);
    item_t it;
    it.kind = k;
    it.edge_index = EW'(idx);
    it.edge_source = VW'(s);
    it.edge_target = VW'(d);
    it.edge_positive = p;
    return it;
  endfunction

  // requests are queued in order; track which entries will be written
  task automatic push(input item_t it);
    if (it.kind == KIND_WRITE && !g_written[it.edge_index]) begin
      g_written[it.edge_index] = 1;
      written_idx = {written_idx, int'(it.edge_index)};
    end
    request_q = {request_q, it};
  endtask

  task automatic wait_idle();
    while (request_q.size() != 0 || in_ch.valid || result_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IW-1:0] idx, input int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DW'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_VERTEX_COUNT) vcount_reg = val & 11'h7FF;
    else ecount_reg = val & 13'h1FFF;
  endtask

  function automatic item_t rand_item(input int nv);
    item_t it;
    int sel, span;
    span = nv > 40 ? 40 : nv;
    sel = $urandom_range(0, 99);
    it = '0;
    it.edge_source = ($urandom_range(0, 6) == 0) ? VW'($urandom) : VW'($urandom_range(0, span));
    it.edge_target = ($urandom_range(0, 6) == 0) ? VW'($urandom) : VW'($urandom_range(0, span));
    it.edge_positive = ($urandom_range(0, 4) < 2);
    if (sel < 55) begin
      it.kind = KIND_WRITE;
      it.edge_index = ($urandom_range(0, 6) == 0) ? EW'($urandom) : EW'($urandom_range(0, 31));
    end else if (sel < 80) begin
      it.kind = KIND_READ;
      it.edge_index = ($urandom_range(0, 5) == 0) ?
                      EW'(written_idx[$urandom_range(0, written_idx.size() - 1)]) :
                      EW'($urandom_range(0, 31));
    end else if (sel < 92) begin
      it.kind = KIND_RUN;
      it.edge_index = EW'($urandom);
    end else begin
      it.kind = 2'd3;
      it.edge_index = EW'($urandom);
    end
    return it;
  endfunction

  initial begin
    int nv, ne, sel;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_WRITE;
    in_ch.edge_index = '0;
    in_ch.edge_source = '0;
    in_ch.edge_target = '0;
    in_ch.edge_positive = 1'b0;
    out_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset config: empty run, ignored kind, extremes of the fields
    push(mk(KIND_RUN, 0, 0, 0, 0));
    push(mk(2'd3, 4095, 1023, 1023, 1));
    push(mk(KIND_WRITE, 4095, 1023, 1023, 1));
    push(mk(KIND_READ, 4095, 0, 0, 0));
    push(mk(KIND_WRITE, 2048, 10'h2AA, 10'h155, 0));
    push(mk(KIND_READ, 2048, 0, 0, 0));
    wait_idle();

    for (int i = 0; i < 32; i++)
      push(mk(KIND_WRITE, i, $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 1)));
    // negative triangle through vertex 0 plus an out-of-range edge
    push(mk(KIND_WRITE, 0, 0, 1, 0));
    push(mk(KIND_WRITE, 1, 1, 2, 0));
    push(mk(KIND_WRITE, 2, 2, 0, 0));
    push(mk(KIND_WRITE, 3, 2, 5, 1));
    wait_idle();
    cfg_write(CFG_VERTEX_COUNT, 4);
    cfg_write(CFG_EDGE_COUNT, 4);
    push(mk(KIND_RUN, 0, 0, 0, 0));
    for (int i = 0; i < 4; i++) push(mk(KIND_READ, i, 0, 0, 0));
    push(mk(KIND_RUN, 0, 0, 0, 0));
    wait_idle();
    cfg_write(CFG_VERTEX_COUNT, 1);
    push(mk(KIND_WRITE, 4, 0, 0, 0));
    push(mk(KIND_RUN, 0, 0, 0, 0));
    wait_idle();
    cfg_write(CFG_VERTEX_COUNT, 2047);
    cfg_write(CFG_EDGE_COUNT, 8191);
    push(mk(KIND_READ, 31, 0, 0, 0));
    push(mk(KIND_WRITE, 31, 1, 1, 1));
    push(mk(KIND_READ, 31, 0, 0, 0));
    wait_idle();
    cfg_write(CFG_EDGE_COUNT, 4096);
    push(mk(KIND_READ, 4095, 0, 0, 0));
    wait_idle();

    for (int ph = 0; ph < 12; ph++) begin
      sel = $urandom_range(0, 9);
      nv = (sel == 0) ? 1 : (sel == 1) ? 1024 : (sel == 2) ? $urandom_range(13, 40) :
           $urandom_range(2, 12);
      ne = (ph == 0) ? 32 : (ph == 1) ? 1 : $urandom_range(1, 32);
      cfg_write(CFG_VERTEX_COUNT, nv);
      cfg_write(CFG_EDGE_COUNT, ne);
      for (int i = 0; i < 66; i++) push(rand_item(nv));
      push(mk(KIND_RUN, 0, 0, 0, 0));
      wait_idle();
    end

    $display("covered %0d writes, %0d reads, %0d runs with %0d cycles cancelled",
             n_writes, n_reads, n_runs, n_cancels);
    $display("%0d results checked, %0d mismatches", n_results, errors);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #10s;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ncc_pkg.sv
hdl/ncc_if.sv
hdl/ncc_ram.sv
hdl/ncc_engine.sv
hdl/negative_cycle_cancelling.sv
tb/tb_negative_cycle_cancelling.sv
